[sv/iwseq_pkg.sv]
// types and constants for the i2c write sequencer
// holds the control word layout, the microprogram step codes and reset values
// no dependencies
package iwseq_pkg;

  localparam int unsigned PcW   = 4;
  localparam int unsigned HoldW = 3;
  localparam int unsigned AddrW = 7;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 3;

  localparam logic [AddrW-1:0] TARGET_ADDR_RST = 7'h50;
  localparam logic [CntW-1:0]  BIT_CNT_LAST    = 3'd7;

  // microprogram step addresses
  localparam logic [PcW-1:0] PC_START_SDA = 4'd0;
  localparam logic [PcW-1:0] PC_START_SCL = 4'd1;
  localparam logic [PcW-1:0] PC_BIT_SDA   = 4'd2;
  localparam logic [PcW-1:0] PC_BIT_SCLH  = 4'd3;
  localparam logic [PcW-1:0] PC_BIT_SCLL  = 4'd4;
  localparam logic [PcW-1:0] PC_ACK_REL   = 4'd5;
  localparam logic [PcW-1:0] PC_ACK_SCLH  = 4'd6;
  localparam logic [PcW-1:0] PC_ACK_SCLL  = 4'd7;
  localparam logic [PcW-1:0] PC_ACK_DRV   = 4'd8;
  localparam logic [PcW-1:0] PC_STOP_SDA  = 4'd9;
  localparam logic [PcW-1:0] PC_STOP_SCL  = 4'd10;
  localparam logic [PcW-1:0] PC_STOP_END  = 4'd11;

  typedef enum logic [1:0] {
    SDA_ZERO = 2'd0,
    SDA_ONE  = 2'd1,
    SDA_BIT  = 2'd2
  } sda_sel_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_LOAD_ADDR = 2'd1,
    ACT_SHIFT     = 2'd2,
    ACT_LOAD_DATA = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    JMP_NEXT      = 2'd0,
    JMP_BIT_LOOP  = 2'd1,
    JMP_BYTE_LOOP = 2'd2,
    JMP_END       = 2'd3
  } jmp_e;

  typedef struct packed {
    logic             scl;
    sda_sel_e         sda_sel;
    logic             drv;
    logic [HoldW-1:0] hold;
    logic             last;
    act_e             act;
    jmp_e             jmp;
    logic [PcW-1:0]   target;
  } ctrl_word_t;

  // datapath flags seen by the branch logic
  typedef struct packed {
    logic bit_last;
    logic addr_phase;
  } dp_status_t;

endpackage

[sv/iwseq_rom.sv]
// control store of the i2c write sequencer: one control word per step
// depends on iwseq_pkg
module iwseq_rom import iwseq_pkg::*; (
  input  logic [PcW-1:0] pc_i,
  output ctrl_word_t     word_o
);

  // microprogram: start, byte loop, ack slot, byte loop again, ack slot, stop
  always_comb begin
    unique case (pc_i)
      PC_START_SDA: word_o = '{1'b1, SDA_ZERO, 1'b1, 3'd5, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_START_SCL: word_o = '{1'b0, SDA_ZERO, 1'b1, 3'd0, 1'b0, ACT_LOAD_ADDR,
                               JMP_NEXT, PC_START_SDA};
      PC_BIT_SDA:   word_o = '{1'b0, SDA_BIT, 1'b1, 3'd1, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_BIT_SCLH:  word_o = '{1'b1, SDA_BIT, 1'b1, 3'd5, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_BIT_SCLL:  word_o = '{1'b0, SDA_BIT, 1'b1, 3'd1, 1'b0, ACT_SHIFT,
                               JMP_BIT_LOOP, PC_BIT_SDA};
      PC_ACK_REL:   word_o = '{1'b0, SDA_ONE, 1'b0, 3'd1, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_ACK_SCLH:  word_o = '{1'b1, SDA_ONE, 1'b0, 3'd5, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_ACK_SCLL:  word_o = '{1'b0, SDA_ONE, 1'b0, 3'd0, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_ACK_DRV:   word_o = '{1'b0, SDA_ONE, 1'b1, 3'd0, 1'b0, ACT_LOAD_DATA,
                               JMP_BYTE_LOOP, PC_BIT_SDA};
      PC_STOP_SDA:  word_o = '{1'b0, SDA_ZERO, 1'b1, 3'd1, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_STOP_SCL:  word_o = '{1'b1, SDA_ZERO, 1'b1, 3'd5, 1'b0, ACT_NONE,
                               JMP_NEXT, PC_START_SDA};
      PC_STOP_END:  word_o = '{1'b1, SDA_ONE, 1'b1, 3'd5, 1'b1, ACT_NONE,
                               JMP_END, PC_START_SDA};
      default:      word_o = '{1'b1, SDA_ONE, 1'b1, 3'd0, 1'b1, ACT_NONE,
                               JMP_END, PC_START_SDA};
    endcase
  end

endmodule

[sv/iwseq_datapath.sv]
// datapath of the i2c write sequencer: shift register, bit counter,
// byte phase flag and the registered result beat; depends on iwseq_pkg
module iwseq_datapath import iwseq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic [AddrW-1:0] target_address_i,
  input  logic             step_i,
  input  ctrl_word_t       word_i,
  output dp_status_t       status_o,
  output logic             scl_level_o,
  output logic             sda_level_o,
  output logic             sda_driven_o,
  output logic [HoldW-1:0] hold_us_o,
  output logic             last_change_o
);

  logic [ByteW-1:0] data_q;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             addr_phase_q, addr_phase_d;
  logic             sda_bit;

  assign status_o.bit_last   = (cnt_q == BIT_CNT_LAST);
  assign status_o.addr_phase = addr_phase_q;

  // sda source select
  always_comb begin
    unique case (word_i.sda_sel)
      SDA_ZERO: sda_bit = 1'b0;
      SDA_ONE:  sda_bit = 1'b1;
      SDA_BIT:  sda_bit = shift_q[ByteW-1];
      default:  sda_bit = 1'b1;
    endcase
  end

  // shift register and counter actions
  always_comb begin
    shift_d      = shift_q;
    cnt_d        = cnt_q;
    addr_phase_d = addr_phase_q;
    if (step_i) begin
      unique case (word_i.act)
        ACT_LOAD_ADDR: begin
          shift_d      = {target_address_i, 1'b0};
          cnt_d        = '0;
          addr_phase_d = 1'b1;
        end
        ACT_SHIFT: begin
          shift_d = {shift_q[ByteW-2:0], 1'b0};
          cnt_d   = cnt_q + 1'b1;
        end
        ACT_LOAD_DATA: begin
          shift_d      = data_q;
          cnt_d        = '0;
          addr_phase_d = 1'b0;
        end
        default: begin
          shift_d = shift_q;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      addr_phase_q <= 1'b1;
    end else begin
      cnt_q        <= cnt_d;
      addr_phase_q <= addr_phase_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (take_i) begin
      data_q <= data_byte_i;
    end
    if (step_i) begin
      scl_level_o   <= word_i.scl;
      sda_level_o   <= sda_bit;
      sda_driven_o  <= word_i.drv;
      hold_us_o     <= word_i.hold;
      last_change_o <= word_i.last;
    end
  end

endmodule

[sv/i2c_master_write_sequencer.sv]
// i2c master write sequencer: each data byte beat expands into 61 line change beats
// the take sets busy_q; the first step then registers the first result beat valid
// throughput: one result beat per cycle while out_stall_i is low; the input stays stalled
// until the single step counter has walked the 12-step microprogram for the byte
// reset: idle, no result pending, target address 0x50
module i2c_master_write_sequencer import iwseq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             scl_level_o,
  output logic             sda_level_o,
  output logic             sda_driven_o,
  output logic [HoldW-1:0] hold_us_o,
  output logic             last_change_o
);

  logic [AddrW-1:0] target_address_q;
  logic             busy_q, busy_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic             out_valid_q, out_valid_d;
  logic             take;
  logic             step;
  ctrl_word_t       word;
  dp_status_t       status;

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign take        = in_valid_i && !busy_q;
  assign step        = busy_q && (!out_valid_q || !out_stall_i);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_address_q <= TARGET_ADDR_RST;
    end else if (cfg_we_i) begin
      target_address_q <= cfg_wdata_i;
    end
  end

  iwseq_rom u_rom (
    .pc_i   (pc_q),
    .word_o (word)
  );

  // step counter and branch logic
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (take) begin
      busy_d = 1'b1;
      pc_d   = PC_START_SDA;
    end else if (step) begin
      unique case (word.jmp)
        JMP_NEXT: begin
          pc_d = pc_q + 1'b1;
        end
        JMP_BIT_LOOP: begin
          pc_d = status.bit_last ? pc_q + 1'b1 : word.target;
        end
        JMP_BYTE_LOOP: begin
          pc_d = status.addr_phase ? word.target : pc_q + 1'b1;
        end
        JMP_END: begin
          busy_d = 1'b0;
          pc_d   = PC_START_SDA;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  // result beat valid
  always_comb begin
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PC_START_SDA;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  iwseq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .data_byte_i      (data_byte_i),
    .target_address_i (target_address_q),
    .step_i           (step),
    .word_i           (word),
    .status_o         (status),
    .scl_level_o      (scl_level_o),
    .sda_level_o      (sda_level_o),
    .sda_driven_o     (sda_driven_o),
    .hold_us_o        (hold_us_o),
    .last_change_o    (last_change_o)
  );

endmodule

[sv/iwseq_checker.sv]
// port-level checks for the i2c write sequencer, bound to the top level
// depends on iwseq_pkg and i2c_master_write_sequencer
module iwseq_checker import iwseq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             scl_level_o,
  input logic             sda_level_o,
  input logic             sda_driven_o,
  input logic [HoldW-1:0] hold_us_o,
  input logic             last_change_o
);

  // a taken byte blocks the input until its transaction is done
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after byte beat");

  // final change is the stop condition: both lines high and driven
  a_last_is_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_change_o |-> scl_level_o && sda_level_o && sda_driven_o)
    else $error("last change is not a stop condition");

  // a released data line reads high
  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_driven_o |-> sda_level_o)
    else $error("released sda not high");

  // hold time is one of the three used values
  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hold_us_o == 3'd0 || hold_us_o == 3'd1 || hold_us_o == 3'd5))
    else $error("hold time out of range");

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scl_level_o)
      && $stable(sda_level_o) && $stable(hold_us_o) && $stable(last_change_o))
    else $error("stalled result beat changed");

endmodule

bind i2c_master_write_sequencer iwseq_checker u_iwseq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .scl_level_o   (scl_level_o),
  .sda_level_o   (sda_level_o),
  .sda_driven_o  (sda_driven_o),
  .hold_us_o     (hold_us_o),
  .last_change_o (last_change_o)
);
